>>> design/tld_pkg.sv
// Shared constants and field widths for the terminal line discipline.
package tld_pkg;

  localparam int CHAR_W     = 8;
  localparam int KIND_W     = 2;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  localparam int DEF_BUFFER_DEPTH = 256;
  localparam int DEF_MAX_READ     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CANONICAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAW       = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ECHO   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS = 8'h08;
  localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SP = 8'h20;

endpackage

>>> design/tld_item_if.sv
// Input channel carrying typed characters and read requests.
interface tld_item_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [tld_pkg::CHAR_W-1:0]  char_in;
  logic [tld_pkg::COUNT_W-1:0] read_count;

  modport source (output valid, func, char_in, read_count, input ready);
  modport sink   (input valid, func, char_in, read_count, output ready);
endinterface

>>> design/tld_result_if.sv
// Output channel carrying echo bytes, read data bytes and status beats.
interface tld_result_if;
  logic                        valid;
  logic                        ready;
  logic [tld_pkg::KIND_W-1:0]  kind;
  logic [tld_pkg::CHAR_W-1:0]  data;
  logic                        accepted;
  logic                        line_done;
  logic                        input_ready;
  logic                        blocked;
  logic [tld_pkg::COUNT_W-1:0] bytes_read;
  logic                        line_available;
  logic                        last;

  modport source (output valid, kind, data, accepted, line_done, input_ready,
                  blocked, bytes_read, line_available, last, input ready);
  modport sink   (input valid, kind, data, accepted, line_done, input_ready,
                  blocked, bytes_read, line_available, last, output ready);
endinterface

>>> design/tld_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/tty_line_discipline_top.sv
// Terminal input line discipline over a non-overwriting byte FIFO in RAM.
//
// The item channel takes typed characters (func 0) and read requests (func 1).
// The result channel returns echo bytes, read data bytes and one status beat,
// marked by last, for every item. The user must write registers through
// wr_en, wr_index and wr_data only while idle; the block does not enforce it.
// One item is worked on at a time; a new item is accepted as soon as the
// status of the previous one sits in the output register.
// A character goes from idle through the echo state, if echo is on, and then
// to the status state; a backspace first reads the newest byte from the RAM.
// A read issues the first RAM read when it is accepted, then fetches the next
// address while a byte is sent.
// Reset empties the FIFO and restores canonical mode with echo on; RAM
// contents are not cleared. When the receiver stalls, the output register
// holds its beat and the sequencer waits; no result is dropped.
module tty_line_discipline_top #(
  parameter int BUFFER_DEPTH = tld_pkg::DEF_BUFFER_DEPTH,
  parameter int MAX_READ     = tld_pkg::DEF_MAX_READ
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [tld_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [tld_pkg::CFG_DATA_W-1:0] wr_data,
  tld_item_if.sink                       item,
  tld_result_if.source                   result
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int MW = (CW > tld_pkg::COUNT_W) ? CW : tld_pkg::COUNT_W;
  localparam logic [AW-1:0] DEPTH_M1 = AW'(BUFFER_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(BUFFER_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BS_READ,
    S_ECHO,
    S_RD_DATA,
    S_STATUS
  } state_t;

  state_t state;

  logic cfg_canon, cfg_echo, cfg_raw;
  logic [AW-1:0] head_ptr, tail_ptr;
  logic [CW-1:0] fill_count, newline_count;
  logic [tld_pkg::CHAR_W-1:0] echo_byte;
  logic [1:0] echo_cnt;
  logic echo_bs;
  logic st_acc, st_lc, st_ir, st_blk;
  logic [tld_pkg::COUNT_W-1:0] st_nread, take_left;

  logic out_valid, out_acc, out_lc, out_ir, out_blk, out_lavail, out_last;
  logic [tld_pkg::KIND_W-1:0] out_kind;
  logic [tld_pkg::CHAR_W-1:0] out_data;
  logic [tld_pkg::COUNT_W-1:0] out_nread;

  logic accept, editing, out_free, out_load, is_bs, is_lf, is_cr, push_ok;
  logic do_push, do_bs, rd_start, emit_byte, byte_lf, stop;
  logic [AW-1:0] head_inc, tail_inc, tail_dec;
  logic [tld_pkg::COUNT_W-1:0] sat_count, take_init;
  logic [MW-1:0] cnt_ext, fill_ext;
  logic [CW-1:0] nl_after_byte;

  logic ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [tld_pkg::CHAR_W-1:0] ram_rdata;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign editing    = cfg_canon && !cfg_raw;
  assign out_free   = !out_valid || result.ready;
  assign out_load   = out_free && ((state == S_ECHO) || (state == S_RD_DATA) ||
                                   (state == S_STATUS));
  assign is_bs      = (item.char_in == tld_pkg::CH_BS);
  assign is_lf      = (item.char_in == tld_pkg::CH_LF);
  assign is_cr      = (item.char_in == tld_pkg::CH_CR);
  assign push_ok    = (fill_count != DEPTH_C);

  assign head_inc = (head_ptr == DEPTH_M1) ? '0 : head_ptr + AW'(1);
  assign tail_inc = (tail_ptr == DEPTH_M1) ? '0 : tail_ptr + AW'(1);
  assign tail_dec = (tail_ptr == '0) ? DEPTH_M1 : tail_ptr - AW'(1);

  always_comb begin
    if (int'(item.read_count) > MAX_READ) begin
      sat_count = tld_pkg::COUNT_W'(MAX_READ);
    end else begin
      sat_count = item.read_count;
    end
    cnt_ext  = MW'(sat_count);
    fill_ext = MW'(fill_count);
    if (fill_ext < cnt_ext) begin
      take_init = tld_pkg::COUNT_W'(fill_ext);
    end else begin
      take_init = sat_count;
    end
  end

  assign do_push  = accept && !item.func && !(editing && is_bs) && push_ok;
  assign do_bs    = accept && !item.func && editing && is_bs && (fill_count != '0);
  assign rd_start = accept && item.func && !(cfg_canon && newline_count == '0)
                    && (take_init != '0);

  assign emit_byte     = (state == S_RD_DATA) && out_free;
  assign byte_lf       = (ram_rdata == tld_pkg::CH_LF);
  assign stop          = (take_left == tld_pkg::COUNT_W'(1)) || (cfg_canon && byte_lf);
  assign nl_after_byte = newline_count - CW'(byte_lf);

  assign ram_rd_en = do_bs || rd_start || (emit_byte && !stop);
  always_comb begin
    if (do_bs) begin
      ram_rd_addr = tail_dec;
    end else if (emit_byte) begin
      ram_rd_addr = head_inc;
    end else begin
      ram_rd_addr = head_ptr;
    end
  end

  tld_ram #(
    .WIDTH (tld_pkg::CHAR_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (do_push),
    .wr_addr (tail_ptr),
    .wr_data (item.char_in),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cfg_canon     <= 1'b1;
      cfg_echo      <= 1'b1;
      cfg_raw       <= 1'b0;
      head_ptr      <= '0;
      tail_ptr      <= '0;
      fill_count    <= '0;
      newline_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          tld_pkg::REG_CANONICAL: cfg_canon <= wr_data[0];
          tld_pkg::REG_ECHO:      cfg_echo  <= wr_data[0];
          tld_pkg::REG_RAW:       cfg_raw   <= wr_data[0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      if (do_push) begin
        tail_ptr      <= tail_inc;
        fill_count    <= fill_count + CW'(1);
        newline_count <= newline_count + CW'(is_lf);
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            st_nread  <= '0;
            echo_byte <= item.char_in;
            echo_bs   <= 1'b0;
            echo_cnt  <= 2'd1;
            if (item.func) begin
              take_left <= take_init;
              st_acc    <= 1'b0;
              st_lc     <= 1'b0;
              st_ir     <= 1'b0;
              st_blk    <= cfg_canon && (newline_count == '0);
              state     <= rd_start ? S_RD_DATA : S_STATUS;
            end else if (!editing) begin
              st_acc <= push_ok;
              st_lc  <= 1'b0;
              st_ir  <= 1'b1;
              st_blk <= 1'b0;
              state  <= (push_ok && cfg_echo) ? S_ECHO : S_STATUS;
            end else if (is_bs) begin
              st_acc <= 1'b1;
              st_lc  <= 1'b0;
              st_ir  <= 1'b0;
              st_blk <= 1'b0;
              state  <= (fill_count != '0) ? S_BS_READ : S_STATUS;
            end else begin
              st_acc <= push_ok;
              st_lc  <= !push_ok || is_lf || is_cr;
              st_ir  <= !push_ok || is_lf || is_cr;
              st_blk <= 1'b0;
              state  <= (push_ok && cfg_echo) ? S_ECHO : S_STATUS;
            end
          end
        end
        S_BS_READ: begin
          tail_ptr      <= tail_dec;
          fill_count    <= fill_count - CW'(1);
          newline_count <= nl_after_byte;
          echo_bs       <= 1'b1;
          echo_cnt      <= 2'd3;
          state         <= cfg_echo ? S_ECHO : S_STATUS;
        end
        S_ECHO: begin
          if (out_free) begin
            out_kind   <= tld_pkg::KIND_ECHO;
            out_acc    <= 1'b0;
            out_lc     <= 1'b0;
            out_ir     <= 1'b0;
            out_blk    <= 1'b0;
            out_nread  <= '0;
            out_lavail <= (newline_count != '0);
            out_last   <= 1'b0;
            if (!echo_bs) begin
              out_data <= echo_byte;
            end else if (echo_cnt == 2'd2) begin
              out_data <= tld_pkg::CH_SP;
            end else begin
              out_data <= tld_pkg::CH_BS;
            end
            echo_cnt <= echo_cnt - 2'd1;
            if (echo_cnt == 2'd1) begin
              state <= S_STATUS;
            end
          end
        end
        S_RD_DATA: begin
          if (emit_byte) begin
            out_kind      <= tld_pkg::KIND_DATA;
            out_data      <= ram_rdata;
            out_acc       <= 1'b0;
            out_lc        <= 1'b0;
            out_ir        <= 1'b0;
            out_blk       <= 1'b0;
            out_nread     <= '0;
            out_lavail    <= (nl_after_byte != '0);
            out_last      <= 1'b0;
            head_ptr      <= head_inc;
            fill_count    <= fill_count - CW'(1);
            newline_count <= nl_after_byte;
            st_nread      <= st_nread + tld_pkg::COUNT_W'(1);
            take_left     <= take_left - tld_pkg::COUNT_W'(1);
            if (stop) begin
              state <= S_STATUS;
            end
          end
        end
        S_STATUS: begin
          if (out_free) begin
            out_kind   <= tld_pkg::KIND_STATUS;
            out_data   <= '0;
            out_acc    <= st_acc;
            out_lc     <= st_lc;
            out_ir     <= st_ir;
            out_blk    <= st_blk;
            out_nread  <= st_nread;
            out_lavail <= (newline_count != '0);
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid          = out_valid;
  assign result.kind           = out_kind;
  assign result.data           = out_data;
  assign result.accepted       = out_acc;
  assign result.line_done      = out_lc;
  assign result.input_ready    = out_ir;
  assign result.blocked        = out_blk;
  assign result.bytes_read     = out_nread;
  assign result.line_available = out_lavail;
  assign result.last           = out_last;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= DEPTH_C)
    else $error("fill count above buffer depth");

  a_newline_bound: assert property (@(posedge clk) disable iff (rst)
    newline_count <= fill_count)
    else $error("more newlines counted than bytes stored");

  a_accept_after_status: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!result.valid || result.last))
    else $error("item accepted while results of the previous item are pending");

  a_blocked_empty: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.blocked) |-> (result.bytes_read == '0 && result.last))
    else $error("blocked status with data returned");

endmodule
